>>> rtl/core/sba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and codes of the slab bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_TOO_BIG  = 2'd2;
    localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

    // smallest class is 16 bytes, a page is 4096 bytes
    localparam int MIN_SIZE_SHIFT = 4;
    localparam int PAGE_SHIFT     = 12;
    localparam int WORD_BITS      = 64;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] request_size;
        logic [15:0] object_handle;
        logic [2:0]  class_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_handle;
        logic        page_claimed;
        logic        page_released;
        logic [12:0] used_objects;
        logic [4:0]  pages_in_use;
    } rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/sba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/slab_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slab_bitmap_allocator
// Eight-class slab allocator keeping one usage bit per object in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries allocate, free, query or
//   no-op commands; rsp channel (rsp_valid, rsp_stall, rsp) returns exactly
//   one result per command, in order.
//   Commands are handled one at a time. Query, no-op, oversize, class-full
//   and out-of-range free commands go from the execute state straight to
//   the done state. Allocate from a fresh page and a free of a clear bit
//   read one bitmap word before finishing. Allocate from a partly used class
//   reads one 64-bit bitmap word per cycle, from the class's first word to
//   the word with the first clear bit (up to MAX_PAGES*4 words). A free that
//   clears a bit then scans the freed page's 1 to 4 words.
//   The single bitmap RAM port pair sets the rate.
//   After reset the bitmap RAM is cleared one word per cycle, all 2^(clog2
//   of classes + clog2 of MAX_PAGES*4) words (512 at default parameters);
//   req_stall stays high during that time.
//   A finished result sits in the output register while rsp_stall is high;
//   the next command is still taken and held until the register frees.
// ----------------------------------------------------------------------------
module slab_bitmap_allocator
    import sba_pkg::*;
#(
    parameter int MAX_PAGES   = 16,
    parameter int NUM_CLASSES = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int BW    = $clog2(MAX_PAGES * 256);
    localparam int WW    = BW - 6;
    localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW    = CW + WW;
    localparam int CNT_W = $clog2(MAX_PAGES * 256 + 1);
    localparam int PG_W  = $clog2(MAX_PAGES + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_CHK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]  clr_ptr_reg, clr_ptr_next;
    logic [1:0]     op_reg, op_next;
    logic           fit_reg, fit_next;
    logic [CW-1:0]  cls_reg, cls_next;
    logic [15:0]    handle_reg, handle_next;
    logic [2:0]     qc_reg, qc_next;
    logic [PW-1:0]  slot_reg, slot_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [WW:0]    rd_ptr_reg, rd_ptr_next;
    logic [WW-1:0]  last_reg, last_next;
    logic [WW-1:0]  chk_w_reg, chk_w_next;
    logic           pend_reg, pend_next;

    logic [1:0]     st_reg, st_next;
    logic [15:0]    rh_reg, rh_next;
    logic           clm_reg, clm_next;
    logic           rel_reg, rel_next;
    logic           rep_en_reg, rep_en_next;
    logic [CW-1:0]  rep_cls_reg, rep_cls_next;

    logic [MAX_PAGES-1:0] present_reg [NUM_CLASSES];
    logic [MAX_PAGES-1:0] present_next [NUM_CLASSES];
    logic [CNT_W-1:0]     free_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]     free_cnt_next [NUM_CLASSES];
    logic [CNT_W-1:0]     used_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0]     used_cnt_next [NUM_CLASSES];
    logic [PG_W-1:0]      page_cnt_reg [NUM_CLASSES];
    logic [PG_W-1:0]      page_cnt_next [NUM_CLASSES];

    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [63:0]    mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [63:0]    mem_rdata;

    sba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(1 << AW)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // per-class shifts: log2 of objects per page and of object size
    logic [3:0]       lp;
    logic [3:0]       sz_sh;
    logic [CNT_W-1:0] per_cnt;
    logic [BW-1:0]    per_b;
    logic [BW:0]      span;
    logic [BW-1:0]    alloc_last_b;
    logic [BW-1:0]    page_b0;
    logic [BW-1:0]    page_b1;
    logic [11:0]      obj;
    logic [PW-1:0]    empty_slot;
    logic             have_empty;
    logic [BW-1:0]    pk;
    logic [63:0]      scan_mask;
    logic [63:0]      cand;
    logic [5:0]       k_first;
    logic             found;
    logic             issue;
    logic [5:0]       bitpos;
    logic [63:0]      onehot;
    logic [BW-1:0]    hit_b;
    logic [31:0]      wide;
    logic [31:0]      u32;
    logic [31:0]      p32;
    logic             fit_c;
    logic [CW-1:0]    cls_c;

    assign lp      = 4'd8 - 4'(cls_reg);
    assign sz_sh   = 4'(MIN_SIZE_SHIFT) + 4'(cls_reg);
    assign per_cnt = CNT_W'(32'd1 << lp);
    assign per_b   = BW'(32'd1 << lp);
    assign span    = (BW + 1)'(MAX_PAGES) << lp;
    assign bitpos  = b_reg[5:0];
    assign onehot  = 64'd1 << bitpos;

    always_comb
    begin
        alloc_last_b = BW'(span - (BW + 1)'(1));
        page_b0      = BW'(slot_reg) << lp;
        page_b1      = page_b0 + per_b - BW'(1);
        obj          = handle_reg[11:0] >> sz_sh;

        // lowest page slot not yet present in the class
        have_empty = 1'b0;
        empty_slot = '0;
        for (int i = MAX_PAGES - 1; i >= 0; i--)
        begin
            if (!present_reg[cls_reg][i])
            begin
                have_empty = 1'b1;
                empty_slot = PW'(i);
            end
        end

        // bits of the checked word that belong to the pages of interest
        for (int k = 0; k < 64; k++)
        begin
            pk = BW'({chk_w_reg, 6'(k)}) >> lp;
            if (op_reg == OP_ALLOC)
            begin
                scan_mask[k] = (32'(pk) < MAX_PAGES) && present_reg[cls_reg][pk[PW-1:0]];
            end
            else
            begin
                scan_mask[k] = (pk == BW'(slot_reg));
            end
        end
        cand = (op_reg == OP_ALLOC) ? (~mem_rdata & scan_mask) : (mem_rdata & scan_mask);
        found = |cand;
        k_first = '0;
        for (int k = 63; k >= 0; k--)
        begin
            if (cand[k])
            begin
                k_first = 6'(k);
            end
        end
        hit_b = BW'({chk_w_reg, k_first});
        issue = (rd_ptr_reg <= {1'b0, last_reg});

        fit_c = 1'b0;
        cls_c = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (32'(req.request_size) <= (32'd16 << c))
            begin
                fit_c = 1'b1;
                cls_c = CW'(c);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_ptr_next   = clr_ptr_reg;
        op_next        = op_reg;
        fit_next       = fit_reg;
        cls_next       = cls_reg;
        handle_next    = handle_reg;
        qc_next        = qc_reg;
        slot_next      = slot_reg;
        b_next         = b_reg;
        rd_ptr_next    = rd_ptr_reg;
        last_next      = last_reg;
        chk_w_next     = chk_w_reg;
        pend_next      = 1'b0;
        st_next        = st_reg;
        rh_next        = rh_reg;
        clm_next       = clm_reg;
        rel_next       = rel_reg;
        rep_en_next    = rep_en_reg;
        rep_cls_next   = rep_cls_reg;
        present_next   = present_reg;
        free_cnt_next  = free_cnt_reg;
        used_cnt_next  = used_cnt_reg;
        page_cnt_next  = page_cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        wide           = '0;
        u32            = '0;
        p32            = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + AW'(1);
                if (clr_ptr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    fit_next    = fit_c;
                    cls_next    = cls_c;
                    handle_next = req.object_handle;
                    qc_next     = req.class_index;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                st_next      = STAT_OK;
                rh_next      = '0;
                clm_next     = 1'b0;
                rel_next     = 1'b0;
                rep_en_next  = 1'b0;
                rep_cls_next = cls_reg;
                state_next   = ST_DONE;
                case (op_reg)
                    OP_NOP:
                    begin
                    end

                    OP_QUERY:
                    begin
                        if (32'(qc_reg) < NUM_CLASSES)
                        begin
                            rep_en_next  = 1'b1;
                            rep_cls_next = CW'(qc_reg);
                        end
                    end

                    default:
                    begin
                        if (!fit_reg)
                        begin
                            st_next = STAT_TOO_BIG;
                        end
                        else
                        begin
                            rep_en_next = 1'b1;
                            if (op_reg == OP_ALLOC)
                            begin
                                if (free_cnt_reg[cls_reg] == '0)
                                begin
                                    if (have_empty)
                                    begin
                                        slot_next  = empty_slot;
                                        b_next     = BW'(empty_slot) << lp;
                                        state_next = ST_RD;
                                    end
                                    else
                                    begin
                                        st_next = STAT_FULL;
                                    end
                                end
                                else
                                begin
                                    rd_ptr_next = '0;
                                    last_next   = alloc_last_b[BW-1:6];
                                    state_next  = ST_SCAN;
                                end
                            end
                            else if (32'(handle_reg[15:12]) >= MAX_PAGES)
                            begin
                                st_next = STAT_NOT_ALLOC;
                            end
                            else
                            begin
                                slot_next  = PW'(handle_reg[15:12]);
                                b_next     = (BW'(handle_reg[15:12]) << lp) | BW'(obj);
                                state_next = ST_RD;
                            end
                        end
                    end
                endcase
            end

            ST_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {cls_reg, b_reg[BW-1:6]};
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                mem_waddr = {cls_reg, b_reg[BW-1:6]};
                if (op_reg == OP_ALLOC)
                begin
                    // fresh page: set its first object
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | onehot;
                    present_next[cls_reg][slot_reg] = 1'b1;
                    page_cnt_next[cls_reg] = page_cnt_reg[cls_reg] + PG_W'(1);
                    free_cnt_next[cls_reg] = free_cnt_reg[cls_reg] + per_cnt - CNT_W'(1);
                    used_cnt_next[cls_reg] = used_cnt_reg[cls_reg] + CNT_W'(1);
                    wide       = 32'(slot_reg) << PAGE_SHIFT;
                    rh_next    = wide[15:0];
                    clm_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!mem_rdata[bitpos])
                begin
                    st_next    = STAT_NOT_ALLOC;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata & ~onehot;
                    free_cnt_next[cls_reg] = free_cnt_reg[cls_reg] + CNT_W'(1);
                    used_cnt_next[cls_reg] = used_cnt_reg[cls_reg] - CNT_W'(1);
                    // then look for any bit left in the page
                    rd_ptr_next = {1'b0, page_b0[BW-1:6]};
                    last_next   = page_b1[BW-1:6];
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = {cls_reg, rd_ptr_reg[WW-1:0]};
                    rd_ptr_next = rd_ptr_reg + (WW + 1)'(1);
                    chk_w_next  = rd_ptr_reg[WW-1:0];
                    pend_next   = 1'b1;
                end
                if (pend_reg && found)
                begin
                    state_next = ST_DONE;
                    if (op_reg == OP_ALLOC)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {cls_reg, chk_w_reg};
                        mem_wdata = mem_rdata | (64'd1 << k_first);
                        free_cnt_next[cls_reg] = free_cnt_reg[cls_reg] - CNT_W'(1);
                        used_cnt_next[cls_reg] = used_cnt_reg[cls_reg] + CNT_W'(1);
                        // bit index times object size is the handle
                        wide    = 32'(hit_b) << sz_sh;
                        rh_next = wide[15:0];
                    end
                end
                else if (!pend_reg && !issue)
                begin
                    state_next = ST_DONE;
                    if (op_reg == OP_ALLOC)
                    begin
                        st_next = STAT_FULL;
                    end
                    else if (present_reg[cls_reg][slot_reg])
                    begin
                        present_next[cls_reg][slot_reg] = 1'b0;
                        page_cnt_next[cls_reg] = page_cnt_reg[cls_reg] - PG_W'(1);
                        free_cnt_next[cls_reg] = free_cnt_reg[cls_reg] - per_cnt;
                        rel_next = 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (rep_en_reg)
                    begin
                        u32 = 32'(used_cnt_reg[rep_cls_reg]);
                        p32 = 32'(page_cnt_reg[rep_cls_reg]);
                    end
                    rsp_next.status        = st_reg;
                    rsp_next.result_handle = rh_reg;
                    rsp_next.page_claimed  = clm_reg;
                    rsp_next.page_released = rel_reg;
                    rsp_next.used_objects  = u32[12:0];
                    rsp_next.pages_in_use  = p32[4:0];
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            op_reg        <= OP_NOP;
            fit_reg       <= 1'b0;
            cls_reg       <= '0;
            handle_reg    <= '0;
            qc_reg        <= '0;
            slot_reg      <= '0;
            b_reg         <= '0;
            rd_ptr_reg    <= '0;
            last_reg      <= '0;
            chk_w_reg     <= '0;
            pend_reg      <= 1'b0;
            st_reg        <= STAT_OK;
            rh_reg        <= '0;
            clm_reg       <= 1'b0;
            rel_reg       <= 1'b0;
            rep_en_reg    <= 1'b0;
            rep_cls_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                present_reg[c]  <= '0;
                free_cnt_reg[c] <= '0;
                used_cnt_reg[c] <= '0;
                page_cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            op_reg        <= op_next;
            fit_reg       <= fit_next;
            cls_reg       <= cls_next;
            handle_reg    <= handle_next;
            qc_reg        <= qc_next;
            slot_reg      <= slot_next;
            b_reg         <= b_next;
            rd_ptr_reg    <= rd_ptr_next;
            last_reg      <= last_next;
            chk_w_reg     <= chk_w_next;
            pend_reg      <= pend_next;
            st_reg        <= st_next;
            rh_reg        <= rh_next;
            clm_reg       <= clm_next;
            rel_reg       <= rel_next;
            rep_en_reg    <= rep_en_next;
            rep_cls_reg   <= rep_cls_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            present_reg   <= present_next;
            free_cnt_reg  <= free_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            page_cnt_reg  <= page_cnt_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_page_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(present_reg[cls_reg]) == 32'(page_cnt_reg[cls_reg]))
        else $error("page count differs from present mask");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !mem_we)
        else $error("bitmap written while no command runs");

    a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.page_released) |->
            (rsp_reg.status == STAT_OK && !rsp_reg.page_claimed))
        else $error("page release with bad status");
`endif

endmodule
`default_nettype wire
